>>> src/airs_pkg.sv
// Shared types and constants for the azimuth indexed ring store.
// Depends on nothing; every other file of the block but airs_checker imports it.
package airs_pkg;

    localparam int SLOTS_DEF       = 4096;
    localparam int HANDLE_BITS_DEF = 32;
    localparam int SHAFT_W         = 12;
    localparam int KEY_W           = 16;
    localparam int QDEPTH          = 2;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef enum logic [2:0] {
        K_ADD,
        K_REJECT,
        K_CLEAR,
        K_READ,
        K_NOP
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic               in_range;
        logic [SHAFT_W-1:0] shaft;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_WIPE,
        ST_CLEAR,
        ST_READ,
        ST_EMIT
    } state_t;

endpackage

>>> src/airs_front.sv
// Front end: holds the type key register, accepts items and classifies them.
// Depends on airs_pkg; pushes classified commands into airs_queue.
module airs_front #(
    parameter int SLOTS       = airs_pkg::SLOTS_DEF,
    parameter int HANDLE_BITS = airs_pkg::HANDLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [1:0]                    op,
    input  logic [airs_pkg::SHAFT_W-1:0]  shaft,
    input  logic [airs_pkg::KEY_W-1:0]    type_key,
    input  logic [31:0]                   message_handle,
    input  logic                          cfg_we,
    input  logic [airs_pkg::KEY_W-1:0]    cfg_data,
    input  airs_pkg::q_stat_t             q_stat,
    input  logic                          init_busy,
    output logic                          busy,
    output logic                          push,
    output airs_pkg::cmd_t                push_cmd,
    output logic [HANDLE_BITS-1:0]        push_handle
);
    import airs_pkg::*;

    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW+SHAFT_W-1:0] SLOTS_E = (CW + SHAFT_W)'(SLOTS);

    logic [KEY_W-1:0]          expected_reg;
    logic [CW+SHAFT_W-1:0]     shaft_ext;
    logic [HANDLE_BITS+31:0]   handle_ext;
    logic                      in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= '0;
        end
        else if (cfg_we)
        begin
            expected_reg <= cfg_data;
        end
    end

    assign busy        = q_stat.full || init_busy;
    assign push        = start && !busy;
    assign shaft_ext   = {{CW{1'b0}}, shaft};
    assign in_range    = shaft_ext < SLOTS_E;
    assign handle_ext  = {{HANDLE_BITS{1'b0}}, message_handle};
    assign push_handle = handle_ext[HANDLE_BITS-1:0];

    always_comb
    begin
        push_cmd.shaft    = shaft;
        push_cmd.in_range = in_range;
        unique case (op)
            OP_ADD:
            begin
                // A slot beyond the store is refused just like a wrong type key.
                if (type_key == expected_reg && in_range)
                    push_cmd.kind = K_ADD;
                else
                    push_cmd.kind = K_REJECT;
            end
            OP_CLEAR: push_cmd.kind = K_CLEAR;
            OP_READ:  push_cmd.kind = K_READ;
            default:  push_cmd.kind = K_NOP;
        endcase
    end

endmodule

>>> src/airs_queue.sv
// Short command queue between the front end and the back end.
// Depends on airs_pkg for its depth and status struct.
module airs_queue #(
    parameter int W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [W-1:0]      push_data,
    input  logic              pop,
    output logic [W-1:0]      head_data,
    output airs_pkg::q_stat_t stat
);
    import airs_pkg::*;

    localparam int PW   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNTW = $clog2(QDEPTH + 1);
    localparam logic [PW-1:0]   LAST_PTR = PW'(QDEPTH - 1);
    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(QDEPTH);

    logic [W-1:0]    entry_reg [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + CNTW'(1);
        else if (pop && !push)
            count_next = count_reg - CNTW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    assign head_data  = entry_reg[rd_ptr_reg];
    assign stat.full  = count_reg == FULL_CNT;
    assign stat.empty = count_reg == '0;

endmodule

>>> src/airs_back.sv
// Back end: slot memories, pointers and the sequencer that carries out commands.
// Depends on airs_pkg; takes commands from airs_queue and drives the result ports.
module airs_back #(
    parameter int SLOTS       = airs_pkg::SLOTS_DEF,
    parameter int HANDLE_BITS = airs_pkg::HANDLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  airs_pkg::q_stat_t      q_stat,
    input  airs_pkg::cmd_t         head_cmd,
    input  logic [HANDLE_BITS-1:0] head_handle,
    output logic                   pop,
    output logic                   init_busy,
    output logic                   done,
    output logic                   status,
    output logic [11:0]            oldest_slot,
    output logic [11:0]            newest_slot,
    output logic [12:0]            used_size,
    output logic                   read_valid,
    output logic [31:0]            read_handle
);
    import airs_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] LAST_SLOT = CW'(SLOTS - 1);
    localparam logic [CW-1:0] ONE       = CW'(1);

    // Slot memories
    logic                   valid_mem [SLOTS];
    logic [HANDLE_BITS-1:0] handle_mem [SLOTS];
    logic                   v_q;
    logic [HANDLE_BITS-1:0] h_q;
    logic                   vwe;
    logic [AW-1:0]          vaddr;
    logic                   vdata;
    logic                   hwe;
    logic [AW-1:0]          haddr;
    logic [AW-1:0]          raddr;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          wp_reg, wp_next;
    logic [CW-1:0]          wend_reg, wend_next;
    logic                   wrap_reg, wrap_next;
    logic [CW-1:0]          used_reg, used_next;
    logic [CW-1:0]          lw_reg, lw_next;
    logic [CW-1:0]          old_reg, old_next;
    logic [CW-1:0]          sh_reg, sh_next;
    logic [HANDLE_BITS-1:0] hd_reg, hd_next;
    logic                   st_reg, st_next;
    logic                   rv_reg, rv_next;
    logic [HANDLE_BITS-1:0] rh_reg, rh_next;
    logic                   done_reg, done_next;

    logic                   status_reg, status_next;
    logic [11:0]            oldest_out_reg, oldest_out_next;
    logic [11:0]            newest_out_reg, newest_out_next;
    logic [12:0]            used_out_reg, used_out_next;
    logic                   rvalid_out_reg, rvalid_out_next;
    logic [31:0]            rhandle_out_reg, rhandle_out_next;

    logic [CW+SHAFT_W-1:0]  head_sh_ext;
    logic [CW-1:0]          head_sh;
    logic [CW-1:0]          used_new;
    logic [CW-1:0]          first_wipe;
    logic [CW-1:0]          sh_plus;
    logic [CW-1:0]          newest;
    logic [CW+11:0]         oldest_ext;
    logic [CW+11:0]         newest_ext;
    logic [CW+12:0]         used_ext;
    logic [HANDLE_BITS+31:0] rh_ext;

    assign head_sh_ext = {{CW{1'b0}}, head_cmd.shaft};
    assign head_sh     = head_sh_ext[CW-1:0];
    assign used_new    = (head_sh >= used_reg) ? head_sh + ONE : used_reg;
    assign first_wipe  = lw_reg + ONE;
    assign sh_plus     = sh_reg + ONE;

    always_comb
    begin
        if (used_reg == '0)
            newest = '0;
        else if (old_reg == '0)
            newest = used_reg - ONE;
        else
            newest = old_reg - ONE;
    end

    assign oldest_ext = {12'b0, old_reg};
    assign newest_ext = {12'b0, newest};
    assign used_ext   = {13'b0, used_reg};
    assign rh_ext     = {32'b0, rh_reg};

    always_comb
    begin
        state_next       = state_reg;
        wp_next          = wp_reg;
        wend_next        = wend_reg;
        wrap_next        = wrap_reg;
        used_next        = used_reg;
        lw_next          = lw_reg;
        old_next         = old_reg;
        sh_next          = sh_reg;
        hd_next          = hd_reg;
        st_next          = st_reg;
        rv_next          = rv_reg;
        rh_next          = rh_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        oldest_out_next  = oldest_out_reg;
        newest_out_next  = newest_out_reg;
        used_out_next    = used_out_reg;
        rvalid_out_next  = rvalid_out_reg;
        rhandle_out_next = rhandle_out_reg;
        pop              = 1'b0;
        vwe              = 1'b0;
        vaddr            = wp_reg[AW-1:0];
        vdata            = 1'b0;
        hwe              = 1'b0;
        haddr            = sh_reg[AW-1:0];
        raddr            = head_sh[AW-1:0];

        unique case (state_reg)
            ST_INIT:
            begin
                // Clearing pass over the valid bits after reset.
                vwe = 1'b1;
                if (wp_reg == LAST_SLOT)
                begin
                    wp_next    = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    wp_next = wp_reg + ONE;
                end
            end
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop     = 1'b1;
                    sh_next = head_sh;
                    hd_next = head_handle;
                    st_next = 1'b0;
                    rv_next = 1'b0;
                    rh_next = '0;
                    unique case (head_cmd.kind)
                        K_ADD:
                        begin
                            used_next = used_new;
                            wp_next   = first_wipe;
                            // When the shaft is not ahead of the last write, the walk
                            // runs to the end of the used range, then restarts at 0.
                            if (head_sh < first_wipe)
                            begin
                                wend_next = used_new;
                                wrap_next = 1'b1;
                            end
                            else
                            begin
                                wend_next = head_sh;
                                wrap_next = 1'b0;
                            end
                            state_next = ST_WIPE;
                        end
                        K_CLEAR:
                        begin
                            wp_next    = '0;
                            state_next = ST_CLEAR;
                        end
                        K_READ:
                        begin
                            rv_next    = head_cmd.in_range;
                            state_next = ST_READ;
                        end
                        K_REJECT:
                        begin
                            st_next    = 1'b1;
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_WIPE:
            begin
                if (wp_reg < wend_reg)
                begin
                    vwe     = 1'b1;
                    wp_next = wp_reg + ONE;
                end
                else if (wrap_reg)
                begin
                    wp_next   = '0;
                    wend_next = sh_reg;
                    wrap_next = 1'b0;
                end
                else
                begin
                    vwe        = 1'b1;
                    vaddr      = sh_reg[AW-1:0];
                    vdata      = 1'b1;
                    hwe        = 1'b1;
                    lw_next    = sh_reg;
                    old_next   = (sh_plus == used_reg) ? '0 : sh_plus;
                    state_next = ST_EMIT;
                end
            end
            ST_CLEAR:
            begin
                // Only slots below the used size can hold a valid bit.
                if (wp_reg < used_reg)
                begin
                    vwe     = 1'b1;
                    wp_next = wp_reg + ONE;
                end
                else
                begin
                    used_next  = '0;
                    lw_next    = ONE;
                    old_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_READ:
            begin
                rv_next    = rv_reg && v_q;
                rh_next    = (rv_reg && v_q) ? h_q : '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                done_next        = 1'b1;
                status_next      = st_reg;
                oldest_out_next  = oldest_ext[11:0];
                newest_out_next  = newest_ext[11:0];
                used_out_next    = used_ext[12:0];
                rvalid_out_next  = rv_reg;
                rhandle_out_next = rh_ext[31:0];
                state_next       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            wp_reg    <= '0;
            wend_reg  <= '0;
            wrap_reg  <= 1'b0;
            used_reg  <= '0;
            lw_reg    <= ONE;
            old_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            wend_reg  <= wend_next;
            wrap_reg  <= wrap_next;
            used_reg  <= used_next;
            lw_reg    <= lw_next;
            old_reg   <= old_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg          <= sh_next;
        hd_reg          <= hd_next;
        st_reg          <= st_next;
        rv_reg          <= rv_next;
        rh_reg          <= rh_next;
        status_reg      <= status_next;
        oldest_out_reg  <= oldest_out_next;
        newest_out_reg  <= newest_out_next;
        used_out_reg    <= used_out_next;
        rvalid_out_reg  <= rvalid_out_next;
        rhandle_out_reg <= rhandle_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (vwe)
            valid_mem[vaddr] <= vdata;
        v_q <= valid_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hwe)
            handle_mem[haddr] <= hd_reg;
        h_q <= handle_mem[raddr];
    end

    assign init_busy   = state_reg == ST_INIT;
    assign done        = done_reg;
    assign status      = status_reg;
    assign oldest_slot = oldest_out_reg;
    assign newest_slot = newest_out_reg;
    assign used_size   = used_out_reg;
    assign read_valid  = rvalid_out_reg;
    assign read_handle = rhandle_out_reg;

endmodule

>>> src/azimuth_indexed_ring_store.sv
// Top level of the azimuth indexed ring store: front end, command queue, back end.
// Depends on airs_pkg, airs_front, airs_queue and airs_back.
//
//   Channel   Handshake                  Payload
//   --------  -------------------------  ------------------------------------------
//   command   start, busy (start&!busy)  op, shaft, type_key, message_handle
//   result    done (one-cycle strobe)    status, oldest_slot, newest_slot,
//                                        used_size, read_valid, read_handle
//   config    cfg_we                     cfg_data (expected type key)
//
// Each item gives exactly one result. In the back end a read fetches the slot, a
// clear invalidates every slot below used_size, and an add walks the valid bits
// one slot per cycle from the slot after the last written one up to the new one,
// restarting at slot 0 when the walk wraps past the end of the used range; a
// rejected add or an unused op goes straight to the result.
// The front end queues up to two items, so busy rises only when the queue is full or the reset pass runs.
// After reset the valid bits are cleared in a pass over every slot with busy high.
// Results cannot be held off by the receiver.
module azimuth_indexed_ring_store #(
    parameter int SLOTS       = airs_pkg::SLOTS_DEF,
    parameter int HANDLE_BITS = airs_pkg::HANDLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    op,
    input  logic [airs_pkg::SHAFT_W-1:0]  shaft,
    input  logic [airs_pkg::KEY_W-1:0]    type_key,
    input  logic [31:0]                   message_handle,
    input  logic                          cfg_we,
    input  logic [airs_pkg::KEY_W-1:0]    cfg_data,
    output logic                          done,
    output logic                          status,
    output logic [11:0]                   oldest_slot,
    output logic [11:0]                   newest_slot,
    output logic [12:0]                   used_size,
    output logic                          read_valid,
    output logic [31:0]                   read_handle
);
    import airs_pkg::*;

    localparam int QW = $bits(cmd_t) + HANDLE_BITS;

    q_stat_t                q_stat;
    logic                   init_busy;
    logic                   push;
    cmd_t                   push_cmd;
    logic [HANDLE_BITS-1:0] push_handle;
    logic                   pop;
    logic [QW-1:0]          head_data;
    cmd_t                   head_cmd;
    logic [HANDLE_BITS-1:0] head_handle;

    airs_front #(
        .SLOTS       (SLOTS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .op             (op),
        .shaft          (shaft),
        .type_key       (type_key),
        .message_handle (message_handle),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .q_stat         (q_stat),
        .init_busy      (init_busy),
        .busy           (busy),
        .push           (push),
        .push_cmd       (push_cmd),
        .push_handle    (push_handle)
    );

    airs_queue #(
        .W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_cmd, push_handle}),
        .pop       (pop),
        .head_data (head_data),
        .stat      (q_stat)
    );

    assign head_cmd    = cmd_t'(head_data[QW-1:HANDLE_BITS]);
    assign head_handle = head_data[HANDLE_BITS-1:0];

    airs_back #(
        .SLOTS       (SLOTS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .head_cmd    (head_cmd),
        .head_handle (head_handle),
        .pop         (pop),
        .init_busy   (init_busy),
        .done        (done),
        .status      (status),
        .oldest_slot (oldest_slot),
        .newest_slot (newest_slot),
        .used_size   (used_size),
        .read_valid  (read_valid),
        .read_handle (read_handle)
    );

endmodule

>>> src/airs_checker.sv
// Port-level checks on the results of the azimuth indexed ring store.
// Depends on the top level's ports only; attached by the bind at the end.
module airs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        done,
    input logic        status,
    input logic [11:0] oldest_slot,
    input logic [11:0] newest_slot,
    input logic [12:0] used_size,
    input logic        read_valid,
    input logic [31:0] read_handle
);

    // Every result passes through an emit step after leaving idle, and the emit step always returns to idle.
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe high in two cycles running");

    a_reject_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> !read_valid)
        else $error("rejected add reports a valid read");

    a_invalid_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !read_valid) |-> (read_handle == 32'd0))
        else $error("handle shown for a slot that holds no message");

    a_empty_pointers: assert property (@(posedge clk) disable iff (!rst_n)
        (done && used_size == 13'd0) |-> (oldest_slot == 12'd0 && newest_slot == 12'd0))
        else $error("empty store reports nonzero pointers");

    a_pointers_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && used_size != 13'd0) |->
            ({1'b0, oldest_slot} < used_size && {1'b0, newest_slot} < used_size))
        else $error("pointer beyond the used size");

endmodule

bind azimuth_indexed_ring_store airs_checker u_airs_checker (.*);

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for azimuth_indexed_ring_store: directed and random add, clear,
// read and unused-op items, checked field by field against a shadow model of the store.
// Depends on airs_pkg and the RTL of the block.
module testbench;
    import airs_pkg::*;

    localparam int         SLOT_COUNT    = SLOTS_DEF;
    localparam logic [1:0] OP_NOP        = 2'd3;
    localparam logic       STATUS_OK     = 1'b0;
    localparam logic       STATUS_REJECT = 1'b1;
    localparam int         STALL_LIMIT   = 40000;
    localparam int         ITEM_TARGET   = 1900;
    localparam int         MAX_PRINTS    = 30;

    typedef struct packed {
        logic        status;
        logic [11:0] oldest;
        logic [11:0] newest;
        logic [12:0] used;
        logic        rvalid;
        logic [31:0] rhandle;
    } slot_report_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          op;
    logic [SHAFT_W-1:0]  shaft;
    logic [KEY_W-1:0]    type_key;
    logic [31:0]         message_handle;
    logic                cfg_we;
    logic [KEY_W-1:0]    cfg_data;
    logic                done;
    logic                status;
    logic [11:0]         oldest_slot;
    logic [11:0]         newest_slot;
    logic [12:0]         used_size;
    logic                read_valid;
    logic [31:0]         read_handle;

    // Shadow copy of the store, updated as items are accepted.
    bit           shadow_valid [SLOT_COUNT];
    logic [31:0]  shadow_handle [SLOT_COUNT];
    int           shadow_used = 0;
    int           shadow_last = 1;
    int           shadow_oldest = 0;
    logic [15:0]  shadow_type = '0;
    slot_report_t expected_reports [$];

    // Stimulus-side bookkeeping: only slots written since reset are ever read.
    bit           ever_written [SLOT_COUNT];
    int           written_list [$];
    logic [15:0]  stim_type = '0;
    int           burst_left = 0;
    int           items_sent = 0;

    int errors = 0;
    int idle_cycles = 0;
    int results_checked = 0;
    int adds_stored = 0;
    int adds_rejected = 0;
    int reads_total = 0;
    int reads_valid = 0;
    int clears_seen = 0;
    int nops_seen = 0;
    int max_used = 0;

    azimuth_indexed_ring_store dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .shaft          (shaft),
        .type_key       (type_key),
        .message_handle (message_handle),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .done           (done),
        .status         (status),
        .oldest_slot    (oldest_slot),
        .newest_slot    (newest_slot),
        .used_size      (used_size),
        .read_valid     (read_valid),
        .read_handle    (read_handle)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic slot_report_t predict_store_step(input logic [1:0] f_op,
                                                        input logic [11:0] f_shaft,
                                                        input logic [15:0] f_key,
                                                        input logic [31:0] f_handle);
        slot_report_t rep;
        int i;
        int newest;
        rep = '0;
        case (f_op)
            OP_ADD:
            begin
                if (f_key != shadow_type)
                begin
                    rep.status = STATUS_REJECT;
                    adds_rejected++;
                end
                else
                begin
                    if (f_shaft >= shadow_used)
                        shadow_used = f_shaft + 1;
                    // Invalidate from the slot after the last write up to the new one,
                    // wrapping through the end of the used range when not ahead.
                    i = shadow_last + 1;
                    if (f_shaft < i)
                    begin
                        while (i < shadow_used)
                        begin
                            shadow_valid[i] = 1'b0;
                            i++;
                        end
                        i = 0;
                    end
                    while (i < f_shaft)
                    begin
                        shadow_valid[i] = 1'b0;
                        i++;
                    end
                    shadow_handle[f_shaft] = f_handle;
                    shadow_valid[f_shaft] = 1'b1;
                    shadow_last = int'(f_shaft);
                    shadow_oldest = f_shaft + 1;
                    if (shadow_oldest == shadow_used)
                        shadow_oldest = 0;
                    adds_stored++;
                    if (shadow_used > max_used)
                        max_used = shadow_used;
                end
            end
            OP_CLEAR:
            begin
                foreach (shadow_valid[k])
                    shadow_valid[k] = 1'b0;
                shadow_used = 0;
                shadow_last = 1;
                shadow_oldest = 0;
                clears_seen++;
            end
            OP_READ:
            begin
                reads_total++;
                if (shadow_valid[f_shaft])
                begin
                    rep.rvalid = 1'b1;
                    rep.rhandle = shadow_handle[f_shaft];
                    reads_valid++;
                end
            end
            default:
                nops_seen++;
        endcase
        if (shadow_used == 0)
            newest = 0;
        else if (shadow_oldest == 0)
            newest = shadow_used - 1;
        else
            newest = shadow_oldest - 1;
        rep.oldest = shadow_oldest[11:0];
        rep.newest = newest[11:0];
        rep.used = shadow_used[12:0];
        return rep;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
            report_mismatch($sformatf("%s expected %0h, got %0h", name, want, got));
    endtask

    // Prediction at acceptance, checking of each result strobe, and the watchdog.
    always @(posedge clk)
    begin : result_monitor
        slot_report_t want;
        if (rst_n)
        begin
            if (cfg_we)
                shadow_type = cfg_data;
            if (start && !busy)
                expected_reports.push_back(
                    predict_store_step(op, shaft, type_key, message_handle));
            if (done)
            begin
                if (expected_reports.size() == 0)
                    report_mismatch($sformatf("result with no item outstanding, used_size %0d",
                                              used_size));
                else
                begin
                    want = expected_reports.pop_front();
                    results_checked++;
                    compare_field("status", 32'(want.status), 32'(status));
                    compare_field("oldest_slot", 32'(want.oldest), 32'(oldest_slot));
                    compare_field("newest_slot", 32'(want.newest), 32'(newest_slot));
                    compare_field("used_size", 32'(want.used), 32'(used_size));
                    compare_field("read_valid", 32'(want.rvalid), 32'(read_valid));
                    compare_field("read_handle", want.rhandle, read_handle);
                end
            end
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("timeout: %0d cycles without progress, %0d results outstanding",
                             idle_cycles, expected_reports.size());
                    $display("[azimuth_indexed_ring_store] ERROR");
                    $finish;
                end
            end
        end
    end

    task automatic send_item(input logic [1:0] i_op, input logic [11:0] i_shaft,
                             input logic [15:0] i_key, input logic [31:0] i_handle);
        @(negedge clk);
        start <= 1'b1;
        op <= i_op;
        shaft <= i_shaft;
        type_key <= i_key;
        message_handle <= i_handle;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        items_sent++;
        if (i_op == OP_ADD && i_key == stim_type && !ever_written[i_shaft])
        begin
            ever_written[i_shaft] = 1'b1;
            written_list.push_back(int'(i_shaft));
        end
    endtask

    task automatic pause_sender(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Bursts of random length; most bursts are followed by a random gap.
    task automatic pace_sender();
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 10));
        end
        burst_left--;
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic set_expected_type(input logic [15:0] value);
        wait_idle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        stim_type = value;
    endtask

    task automatic test_directed_cases();
        set_expected_type(16'h0000);
        send_item(OP_NOP, 12'hFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_ADD, 12'd0, 16'h0000, 32'h0000_0000);
        send_item(OP_ADD, 12'd0, 16'hFFFF, 32'hFFFF_FFFF);
        // Top slot: the store grows to its full size and the walk covers it.
        send_item(OP_ADD, 12'hFFF, 16'h0000, 32'hFFFF_FFFF);
        send_item(OP_READ, 12'hFFF, 16'h0000, 32'h0);
        send_item(OP_READ, 12'd0, 16'hFFFF, 32'h0);
        // Shaft behind the last write wraps past the end to slot 0.
        send_item(OP_ADD, 12'd3, 16'h0000, 32'h5A5A_5A5A);
        send_item(OP_READ, 12'd0, 16'h0000, 32'h0);
        send_item(OP_READ, 12'd3, 16'h0000, 32'h0);
        // Same shaft again invalidates the whole revolution around it.
        send_item(OP_ADD, 12'd3, 16'h0000, 32'hA5A5_A5A5);
        send_item(OP_READ, 12'hFFF, 16'h0000, 32'h0);
        send_item(OP_ADD, 12'd4, 16'h0000, 32'h1234_5678);
        send_item(OP_READ, 12'd3, 16'h0000, 32'h0);
        send_item(OP_CLEAR, 12'hFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_READ, 12'd4, 16'h0000, 32'h0);
        send_item(OP_ADD, 12'd1, 16'h0000, 32'h0000_0001);
        send_item(OP_ADD, 12'd2, 16'h0000, 32'h0000_0000);
        send_item(OP_READ, 12'd1, 16'h0000, 32'h0);
        send_item(OP_ADD, 12'd0, 16'h0000, 32'h8765_4321);
        send_item(OP_READ, 12'd2, 16'h0000, 32'h0);
    endtask

    task automatic test_type_extremes();
        set_expected_type(16'hFFFF);
        send_item(OP_ADD, 12'd2048, 16'hFFFF, 32'h8000_0001);
        send_item(OP_ADD, 12'd2048, 16'h0000, 32'h7FFF_FFFE);
        send_item(OP_READ, 12'd2048, 16'h0000, 32'h0);
        send_item(OP_NOP, 12'd0, 16'h0000, 32'h0);
    endtask

    // One revolution phase: a new type key, a clear, then mostly adds at adjacent
    // shaft positions with reads, rejected adds, unused ops and clears mixed in.
    task automatic run_revolution_phase(input int phase);
        int rev;
        int pos;
        int pick;
        int step;
        int prev;
        logic [15:0] key_value;
        case (phase % 3)
            0: key_value = 16'h0000;
            1: key_value = 16'hFFFF;
            default: key_value = 16'($urandom);
        endcase
        set_expected_type(key_value);
        if (phase % 10 == 9)
            rev = SLOT_COUNT;
        else if (phase % 4 == 3)
            rev = $urandom_range(256, 1024);
        else
            rev = $urandom_range(2, 64);
        send_item(OP_CLEAR, 12'($urandom), 16'($urandom), $urandom);
        pos = $urandom_range(0, rev - 1);
        repeat ($urandom_range(40, 80))
        begin
            pace_sender();
            pick = $urandom_range(0, 99);
            if (pick < 72)
            begin
                send_item(OP_ADD, 12'(pos), key_value, $urandom);
                step = $urandom_range(0, 19);
                if (step < 15)
                    pos = (pos + 1) % rev;
                else if (step < 17)
                    pos = (pos + $urandom_range(2, 8)) % rev;
                else if (step == 18)
                    pos = $urandom_range(0, rev - 1);
            end
            else if (pick < 84)
            begin
                prev = (pos + rev - 1) % rev;
                if (written_list.size() == 0)
                    send_item(OP_NOP, 12'($urandom), 16'($urandom), $urandom);
                else if ($urandom_range(0, 1) == 0 && ever_written[prev])
                    send_item(OP_READ, 12'(prev), 16'($urandom), $urandom);
                else
                    send_item(OP_READ,
                              12'(written_list[$urandom_range(0, written_list.size() - 1)]),
                              16'($urandom), $urandom);
            end
            else if (pick < 92)
                send_item(OP_ADD, 12'($urandom_range(0, rev - 1)),
                          key_value ^ 16'($urandom_range(1, 65535)), $urandom);
            else if (pick < 97)
                send_item(OP_NOP, 12'($urandom), 16'($urandom), $urandom);
            else
                send_item(OP_CLEAR, 12'($urandom), 16'($urandom), $urandom);
        end
    endtask

    task automatic test_random_revolutions();
        int phase;
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            run_revolution_phase(phase);
            phase++;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_ADD;
        shaft = '0;
        type_key = '0;
        message_handle = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_type_extremes();
        test_random_revolutions();

        wait_idle();
        repeat (20) @(posedge clk);
        if (expected_reports.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_reports.size()));

        $display("covered %0d items, %0d results checked: %0d adds stored, %0d rejected,",
                 items_sent, results_checked, adds_stored, adds_rejected);
        $display("%0d reads (%0d of valid slots), %0d clears, %0d unused ops, largest size %0d",
                 reads_total, reads_valid, clears_seen, nops_seen, max_used);
        if (errors == 0)
            $display("[azimuth_indexed_ring_store] OK");
        else
            $display("[azimuth_indexed_ring_store] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
src/airs_pkg.sv
src/airs_front.sv
src/airs_queue.sv
src/airs_back.sv
src/azimuth_indexed_ring_store.sv
src/airs_checker.sv
sim/testbench.sv
